FILE: design/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared constants and types for the LRU block cache.
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int ENTRIES     = 64;
    localparam int BLOCK_WORDS = 32;

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int WIDX_W  = 5;
    localparam int WORD_W  = 64;
    localparam int TAG_W   = 40;
    localparam int CFG_W   = 7;
    localparam int CNT_W   = 32;
    localparam int SLOT_W  = 6;
    localparam int BW_W    = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
    localparam int DATA_AW = IDX_W + BW_W;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 144;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_AGE,
        ST_AGE_END,
        ST_RESP,
        ST_STREAM,
        ST_LOAD
    } t_state;

endpackage

FILE: design/lbc_ram.sv
// ----------------------------------------------------------------------------
// lbc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: design/lru_block_cache_top.sv
// ----------------------------------------------------------------------------
// lru_block_cache_top
// Fully associative LRU cache of 32-word blocks with stream request/result.
// ----------------------------------------------------------------------------
// One request is taken at a time. A get or a put with word index 0 scans the
// tag and age memories one entry per cycle and then makes a decision in a
// decide state. A get miss then returns its result. A get hit or a put then
// walks the age memory again to update ranks, and a put then returns its
// result. A get hit then streams BLOCK_WORDS words from the data memory at one
// word per cycle while the output is not stalled. A put with a nonzero word
// index is written in the cycle it is accepted. The tag compare and the rank
// update are two separate passes over the memories, which together with the
// result words set the request time.
module lru_block_cache_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [lbc_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // device_id, sector_num, block_num, word_index, data_word
    input  logic [lbc_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // req_type
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // slot, out_word, out_index, hit_total, miss_total
    output logic [lbc_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // hit
    output logic                            o_m_tuser,
    output logic                            o_m_tlast
);

    import lbc_pkg::*;

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_cfg, n_cfg;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [IDX_W-1:0]   r_put_slot, n_put_slot;
    logic [CNT_W-1:0]   r_hit_cnt, n_hit_cnt, r_miss_cnt, n_miss_cnt;

    logic               r_is_put, n_is_put;
    logic [TAG_W-1:0]   r_tag, n_tag;
    logic [WORD_W-1:0]  r_data, n_data;
    logic [IDX_W-1:0]   r_cnt, n_cnt;
    logic               r_chk, n_chk;
    logic [IDX_W-1:0]   r_chk_idx, n_chk_idx;
    logic               r_found, n_found;
    logic [IDX_W-1:0]   r_f, n_f;
    logic [IDX_W-1:0]   r_frank, n_frank;
    logic               r_empty, n_empty;
    logic [IDX_W-1:0]   r_eidx, n_eidx;
    logic [IDX_W-1:0]   r_top, n_top;
    logic [IDX_W-1:0]   r_best, n_best;
    logic [IDX_W-1:0]   r_e, n_e;
    logic [IDX_W-1:0]   r_limit, n_limit;
    logic               r_all, n_all;
    logic               r_rhit, n_rhit;
    logic [BW_W-1:0]    r_w, n_w;

    logic               r_out_valid, n_out_valid;
    logic               r_out_hit, n_out_hit;
    logic [SLOT_W-1:0]  r_out_slot, n_out_slot;
    logic [WORD_W-1:0]  r_out_word, n_out_word;
    logic [WIDX_W-1:0]  r_out_idx, n_out_idx;
    logic               r_out_last, n_out_last;
    logic [CNT_W-1:0]   r_out_hcnt, n_out_hcnt, r_out_mcnt, n_out_mcnt;

    logic               tag_we, tag_re;
    logic [IDX_W-1:0]   tag_waddr, tag_raddr;
    logic [TAG_W-1:0]   tag_rd;
    logic               age_we, age_re;
    logic [IDX_W-1:0]   age_waddr, age_raddr, age_wdata, age_rd;
    logic               dat_we, dat_re;
    logic [DATA_AW-1:0] dat_waddr, dat_raddr;
    logic [WORD_W-1:0]  dat_wdata, dat_rd;

    logic [IDX_W:0]     w_n;
    logic [IDX_W-1:0]   w_last;
    logic               w_accept, w_out_free, w_tv, w_match;
    logic [TAG_W-1:0]   w_in_tag;
    logic [WIDX_W-1:0]  w_widx;

    lbc_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag_ram (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(tag_waddr), .i_wdata(r_tag),
        .i_re(tag_re), .i_raddr(tag_raddr), .o_rdata(tag_rd)
    );

    lbc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_age_ram (
        .i_clk(i_clk), .i_we(age_we), .i_waddr(age_waddr), .i_wdata(age_wdata),
        .i_re(age_re), .i_raddr(age_raddr), .o_rdata(age_rd)
    );

    lbc_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES * BLOCK_WORDS)) u_data_ram (
        .i_clk(i_clk), .i_we(dat_we), .i_waddr(dat_waddr), .i_wdata(dat_wdata),
        .i_re(dat_re), .i_raddr(dat_raddr), .o_rdata(dat_rd)
    );

    always_comb begin
        if (r_cfg == '0) begin
            w_n = (IDX_W+1)'(1);
        end else if (int'(r_cfg) > ENTRIES) begin
            w_n = (IDX_W+1)'(ENTRIES);
        end else begin
            w_n = (IDX_W+1)'(r_cfg);
        end
    end

    assign w_last     = IDX_W'(w_n - 1'b1);
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_in_tag   = i_s_tdata[39:0];
    assign w_widx     = i_s_tdata[44:40];
    assign w_tv       = r_valid[r_chk_idx];
    assign w_match    = w_tv && (tag_rd == r_tag);

    always_comb begin
        n_state     = r_state;
        n_cfg       = r_cfg;
        n_valid     = r_valid;
        n_put_slot  = r_put_slot;
        n_hit_cnt   = r_hit_cnt;
        n_miss_cnt  = r_miss_cnt;
        n_is_put    = r_is_put;
        n_tag       = r_tag;
        n_data      = r_data;
        n_cnt       = r_cnt;
        n_chk       = r_chk;
        n_chk_idx   = r_chk_idx;
        n_found     = r_found;
        n_f         = r_f;
        n_frank     = r_frank;
        n_empty     = r_empty;
        n_eidx      = r_eidx;
        n_top       = r_top;
        n_best      = r_best;
        n_e         = r_e;
        n_limit     = r_limit;
        n_all       = r_all;
        n_rhit      = r_rhit;
        n_w         = r_w;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_hit   = r_out_hit;
        n_out_slot  = r_out_slot;
        n_out_word  = r_out_word;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        n_out_hcnt  = r_out_hcnt;
        n_out_mcnt  = r_out_mcnt;

        tag_we    = 1'b0;
        tag_waddr = r_e;
        tag_re    = 1'b0;
        tag_raddr = r_cnt;
        age_we    = 1'b0;
        age_waddr = r_chk_idx;
        age_wdata = '0;
        age_re    = 1'b0;
        age_raddr = r_cnt;
        dat_we    = 1'b0;
        dat_waddr = {r_put_slot, BW_W'(w_widx)};
        dat_wdata = i_s_tdata[108:45];
        dat_re    = 1'b0;
        dat_raddr = {r_e, r_w};

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser == REQ_PUT && w_widx != '0) begin
                        if (int'(w_widx) < BLOCK_WORDS) begin
                            dat_we = 1'b1;
                        end
                    end else begin
                        n_is_put = (i_s_tuser == REQ_PUT);
                        n_tag    = w_in_tag;
                        n_data   = i_s_tdata[108:45];
                        n_cnt    = '0;
                        n_chk    = 1'b0;
                        n_found  = 1'b0;
                        n_empty  = 1'b0;
                        n_top    = '0;
                        n_best   = '0;
                        n_state  = ST_SCAN;
                    end
                end
            end
            ST_SCAN, ST_SCAN_END: begin
                if (r_chk) begin
                    if (w_match && !r_found) begin
                        n_found = 1'b1;
                        n_f     = r_chk_idx;
                        n_frank = age_rd;
                    end
                    if (!w_tv && !r_empty) begin
                        n_empty = 1'b1;
                        n_eidx  = r_chk_idx;
                    end
                    if (r_chk_idx == '0 || age_rd > r_top) begin
                        n_top  = age_rd;
                        n_best = r_chk_idx;
                    end
                end
                if (r_state == ST_SCAN) begin
                    tag_re    = 1'b1;
                    age_re    = 1'b1;
                    n_chk     = 1'b1;
                    n_chk_idx = r_cnt;
                    if (r_cnt == w_last) begin
                        n_state = ST_SCAN_END;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end else begin
                    n_chk   = 1'b0;
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_cnt  = '0;
                n_rhit = r_found;
                n_all  = 1'b0;
                if (!r_is_put) begin
                    if (!r_found) begin
                        if (r_miss_cnt != '1) n_miss_cnt = r_miss_cnt + 1'b1;
                        n_e     = '0;
                        n_state = ST_RESP;
                    end else begin
                        if (r_hit_cnt != '1) n_hit_cnt = r_hit_cnt + 1'b1;
                        n_e     = r_f;
                        n_limit = r_frank;
                        n_state = ST_AGE;
                    end
                end else begin
                    priority if (r_found) begin
                        n_e     = r_f;
                        n_limit = r_frank;
                    end else if (r_empty) begin
                        n_e   = r_eidx;
                        n_all = 1'b1;
                    end else begin
                        n_e     = r_best;
                        n_limit = r_top;
                    end
                    if (!r_found) begin
                        tag_we         = 1'b1;
                        tag_waddr      = n_e;
                        n_valid[n_e]   = 1'b1;
                        if (r_miss_cnt != '1) n_miss_cnt = r_miss_cnt + 1'b1;
                    end
                    dat_we     = 1'b1;
                    dat_waddr  = {n_e, BW_W'(0)};
                    dat_wdata  = r_data;
                    n_put_slot = n_e;
                    n_state    = ST_AGE;
                end
            end
            ST_AGE, ST_AGE_END: begin
                if (r_chk) begin
                    if (r_chk_idx == r_e) begin
                        age_we    = 1'b1;
                        age_wdata = '0;
                    end else if (w_tv && (r_all || age_rd < r_limit)) begin
                        age_we    = 1'b1;
                        age_wdata = age_rd + 1'b1;
                    end
                end
                if (r_state == ST_AGE) begin
                    age_re    = 1'b1;
                    n_chk     = 1'b1;
                    n_chk_idx = r_cnt;
                    if (r_cnt == w_last) begin
                        n_state = ST_AGE_END;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end else begin
                    n_chk   = 1'b0;
                    n_state = r_is_put ? ST_RESP : ST_STREAM;
                end
            end
            ST_RESP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_rhit;
                    n_out_slot  = SLOT_W'(r_e);
                    n_out_word  = '0;
                    n_out_idx   = '0;
                    n_out_last  = 1'b1;
                    n_out_hcnt  = r_hit_cnt;
                    n_out_mcnt  = r_miss_cnt;
                    n_state     = ST_IDLE;
                end
            end
            ST_STREAM: begin
                n_w       = '0;
                dat_re    = 1'b1;
                dat_raddr = {r_e, BW_W'(0)};
                n_state   = ST_LOAD;
            end
            ST_LOAD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = 1'b1;
                    n_out_slot  = SLOT_W'(r_e);
                    n_out_word  = dat_rd;
                    n_out_idx   = WIDX_W'(r_w);
                    n_out_last  = (int'(r_w) == BLOCK_WORDS - 1);
                    n_out_hcnt  = r_hit_cnt;
                    n_out_mcnt  = r_miss_cnt;
                    if (int'(r_w) == BLOCK_WORDS - 1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_w       = r_w + 1'b1;
                        dat_re    = 1'b1;
                        dat_raddr = {r_e, BW_W'(r_w + 1'b1)};
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (i_cfg_wen) begin
            n_cfg      = i_cfg_wdata;
            n_valid    = '0;
            n_put_slot = '0;
            n_hit_cnt  = '0;
            n_miss_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg       <= CFG_W'(ENTRIES);
            r_valid     <= '0;
            r_put_slot  <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg       <= n_cfg;
            r_valid     <= n_valid;
            r_put_slot  <= n_put_slot;
            r_hit_cnt   <= n_hit_cnt;
            r_miss_cnt  <= n_miss_cnt;
            r_chk       <= n_chk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_put   <= n_is_put;
        r_tag      <= n_tag;
        r_data     <= n_data;
        r_cnt      <= n_cnt;
        r_chk_idx  <= n_chk_idx;
        r_found    <= n_found;
        r_f        <= n_f;
        r_frank    <= n_frank;
        r_empty    <= n_empty;
        r_eidx     <= n_eidx;
        r_top      <= n_top;
        r_best     <= n_best;
        r_e        <= n_e;
        r_limit    <= n_limit;
        r_all      <= n_all;
        r_rhit     <= n_rhit;
        r_w        <= n_w;
        r_out_hit  <= n_out_hit;
        r_out_slot <= n_out_slot;
        r_out_word <= n_out_word;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
        r_out_hcnt <= n_out_hcnt;
        r_out_mcnt <= n_out_mcnt;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_hit;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {5'b0, r_out_mcnt, r_out_hcnt, r_out_idx, r_out_word, r_out_slot};

endmodule
